[rtl/ps2_mouse_packet_to_hid_queue_assert.svh]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_to_hid_queue assertion macros
// shared concurrent assertion forms, sampled on clk
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TO_HID_QUEUE_ASSERT_SVH
`define PS2_MOUSE_PACKET_TO_HID_QUEUE_ASSERT_SVH

// check that holds outside reset
`define PS2MQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds at every edge, reset included
`define PS2MQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ps2mq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_pkg
// shared types and constants of the ps/2 mouse to hid report queue
// ----------------------------------------------------------------------------
package ps2mq_pkg;

    // report ring, one slot always kept free
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_IDX_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // packet framing
    localparam logic [1:0] LAST_BYTE_POS = 2'd3;

    // status byte layout
    localparam int ST_X_SIGN = 4;
    localparam int ST_Y_SIGN = 5;
    localparam int ST_X_OVF  = 6;
    localparam int ST_Y_OVF  = 7;

    localparam logic [7:0] CLAMP_NEG = 8'h81; // -127
    localparam logic [7:0] CLAMP_POS = 8'h7F; // 127
    localparam logic [7:0] MOST_NEG  = 8'h80; // -128

    localparam int OUT_FIELDS_W = 8 + 3 + 8 + 8 + 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic
    {
        CMD_BYTE = 1'b0,
        CMD_POLL = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed
    {
        logic [2:0]  buttons;
        logic [7:0]  x_move;
        logic [7:0]  y_move;
        logic [7:0]  wheel;
    } report_t;

    // saturate one axis from its sign and overflow bits
    function automatic logic [7:0] clamp_axis(input logic [7:0] raw,
                                              input logic       neg,
                                              input logic       ovf);
        logic [7:0] res;
        if (neg)
        begin
            res = (!ovf && raw[7] && (raw != MOST_NEG)) ? raw : CLAMP_NEG;
        end
        else
        begin
            res = (!ovf && !raw[7]) ? raw : CLAMP_POS;
        end
        return res;
    endfunction

endpackage

[rtl/ps2_mouse_packet_to_hid_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_to_hid_queue
// ps/2 wheel-mouse bytes in, hid mouse reports out through a report ring
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  --------------------------------------
//  s_*       in   s_tvalid / s_tready  tuser: command, tdata: ps/2 byte
//  m_*       out  m_tvalid / m_tready  tdata: id, buttons, x, y, wheel
//  cfg_*     in   cfg_wen              cfg_wdata: report identifier
//
//  one transfer per cycle in while s_tready is high; the back end executes commands
//  from the registered command queue; a poll's report leaves the result register
//  a byte never waits in the back end; a poll waits while a result is held with
//  m_tready low, and then the two-entry command queue fills and s_tready drops
//  reset clears pointers, packet position and holding bytes; report id = 1
//  the ring has no clearing pass: a slot is only read after it is written
//
module ps2_mouse_packet_to_hid_queue
    import ps2mq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] data_byte
    input  logic                    s_tuser,   // [0] command: 0 byte, 1 poll
    // report stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // [7:0] report_ident, [10:8] buttons,
                                               // [18:11] x_move, [26:19] y_move,
                                               // [34:27] wheel, rest zero
    // report identifier register
    input  logic                    cfg_wen,
    input  logic [7:0]              cfg_wdata
);

    // classified commands from front to back
    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;

    // front: takes transfers and queues tagged commands
    ps2mq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: builds packets, converts, stores and pops reports in order
    ps2mq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/ps2mq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_front
// accepts stream items, tags them byte or poll, queues them for the back end
// ----------------------------------------------------------------------------
module ps2mq_front
    import ps2mq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t                   slot_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [CMDQ_IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CMDQ_CNT_W-1:0]  count_reg, count_next;
    cmd_t                   in_cmd;
    logic                   push, pop;

    always_comb
    begin
        in_cmd.kind = s_tuser ? CMD_POLL : CMD_BYTE;
        in_cmd.data = s_tdata;
    end

    assign s_tready  = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_idx_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_idx_next = (wr_idx_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (pop)
        begin
            rd_idx_next = (rd_idx_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_idx_reg] <= in_cmd;
        end
    end

endmodule

[rtl/ps2mq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_back
// packet assembly, report conversion, report ring and result register
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_to_hid_queue_assert.svh"

module ps2mq_back
    import ps2mq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    input  logic                    cfg_wen,
    input  logic [7:0]              cfg_wdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    report_t             ring_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [1:0]          byte_count_reg;
    logic [7:0]          status_reg, x_reg, y_reg;
    logic [7:0]          report_id_reg;
    logic                out_valid_reg;
    report_t             out_report_reg;
    logic [7:0]          out_ident_reg;

    logic                can_load, ring_empty, ring_full;
    logic                fire, byte_fire, pop_fire, push_fire;
    logic [7:0]          x_clamped, y_clamped;
    report_t             new_report;

    assign can_load   = !out_valid_reg || m_tready;
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign ring_full  = (wr_ptr_next == rd_ptr_reg);

    // bytes never wait; a poll waits only for room in the result register
    assign cmd_ready = (cmd.kind == CMD_BYTE) || can_load;
    assign fire      = cmd_valid && cmd_ready;
    assign byte_fire = fire && (cmd.kind == CMD_BYTE);
    assign pop_fire  = fire && (cmd.kind == CMD_POLL) && !ring_empty;
    assign push_fire = byte_fire && (byte_count_reg == LAST_BYTE_POS) && !ring_full;

    always_comb
    begin
        x_clamped = clamp_axis(x_reg, status_reg[ST_X_SIGN], status_reg[ST_X_OVF]);
        y_clamped = clamp_axis(y_reg, status_reg[ST_Y_SIGN], status_reg[ST_Y_OVF]);
        new_report.buttons = status_reg[2:0];
        new_report.x_move  = x_clamped;
        new_report.y_move  = 8'd0 - y_clamped;
        new_report.wheel   = 8'd0 - cmd.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            status_reg     <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            report_id_reg  <= 8'd1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                report_id_reg <= cfg_wdata;
            end
            if (byte_fire)
            begin
                case (byte_count_reg)
                    2'd0:    status_reg <= cmd.data;
                    2'd1:    x_reg      <= cmd.data;
                    2'd2:    y_reg      <= cmd.data;
                    default: ;
                endcase
                byte_count_reg <= byte_count_reg + 1'b1;
            end
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (pop_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            ring_mem[wr_ptr_reg] <= new_report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            out_report_reg <= ring_mem[rd_ptr_reg];
            out_ident_reg  <= report_id_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       out_report_reg.wheel,
                       out_report_reg.y_move,
                       out_report_reg.x_move,
                       out_report_reg.buttons,
                       out_ident_reg};

    `PS2MQ_ASSERT(a_no_pop_empty, pop_fire |-> (wr_ptr_reg != rd_ptr_reg), "pop from empty ring")
    `PS2MQ_ASSERT(a_no_push_full, push_fire |=> (wr_ptr_reg != rd_ptr_reg), "push made ring look empty")
    `PS2MQ_ASSERT(a_pop_shows, pop_fire |=> out_valid_reg, "popped report not presented")
    `PS2MQ_ASSERT(a_no_overwrite, (out_valid_reg && !m_tready) |-> !pop_fire, "pending result overwritten")

endmodule
